@@ rtl/core/qmix_pkg.sv @@
`timescale 1ns / 1ps
package qmix_pkg;
    localparam int unsigned MaxSpeedDefault = 2618;
    localparam int TermW = 48;
    localparam int SumW  = 51;
    localparam int SqW   = 32;
    localparam int SpdW  = 16;
    localparam int SqrtStages = 4;

    typedef enum logic [1:0] {
        t_reg_active     = 2'd0,
        t_reg_thrust     = 2'd1,
        t_reg_roll_pitch = 2'd2,
        t_reg_yaw        = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SqW-1:0] v1;
        logic [SqW-1:0] v2;
        logic [SqW-1:0] v3;
        logic [SqW-1:0] v4;
    } t_sq_set;
endpackage

@@ rtl/core/qmix_term.sv @@
`timescale 1ns / 1ps
module qmix_term import qmix_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [31:0]      i_demand,
    input  logic        [31:0]      i_gain,
    output logic signed [TermW-1:0] o_term
);
    logic signed [64:0] w_prod;
    logic signed [TermW-1:0] r_term;

    // arithmetic shift floors toward minus infinity
    assign w_prod = 65'(i_demand) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= TermW'(w_prod >>> 16);
        end
    end

    assign o_term = r_term;
endmodule

@@ rtl/core/qmix_sqrt.sv @@
`timescale 1ns / 1ps
module qmix_sqrt import qmix_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SqW-1:0]  i_value,
    output logic [SpdW-1:0] o_root
);
    localparam int Stages   = SqrtStages;
    localparam int StepsPer = SpdW / Stages;

    logic [SqW-1:0]  r_rem  [Stages];
    logic [SpdW-1:0] r_root [Stages];
    logic [SqW-1:0]  r_val  [Stages];

    // restoring square root, StepsPer result bits per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < Stages; s++) begin
                logic [SqW+1:0]  rem;
                logic [SpdW-1:0] root;
                logic [SqW-1:0]  val;
                logic [SqW+1:0]  trial;
                rem  = (s == 0) ? '0 : {2'b0, r_rem[s-1]};
                root = (s == 0) ? '0 : r_root[s-1];
                val  = (s == 0) ? i_value : r_val[s-1];
                for (int k = 0; k < StepsPer; k++) begin
                    rem   = {rem[SqW-1:0], val[SqW-1 -: 2]};
                    val   = {val[SqW-3:0], 2'b00};
                    trial = {{(SqW-SpdW){1'b0}}, root, 2'b01};
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[SpdW-2:0], 1'b1};
                    end else begin
                        root = {root[SpdW-2:0], 1'b0};
                    end
                end
                r_rem[s]  <= rem[SqW-1:0];
                r_root[s] <= root;
                r_val[s]  <= val;
            end
        end
    end

    assign o_root = r_root[Stages-1];
endmodule

@@ rtl/core/quadrotor_motor_mixer.sv @@
`timescale 1ns / 1ps
// Quadrotor X motor mixer.
// Input channel: i_valid / o_stall with thrust and roll/pitch/yaw torques
// (signed Q16.16). Output channel: o_valid / i_stall with four rotor speeds
// (unsigned Q12.4). Configuration: i_cfg_we / i_cfg_idx / i_cfg_data;
// index 0 active, 1 thrust gain, 2 roll/pitch gain, 3 yaw gain (Q24.8).
// Write configuration only while the pipeline is empty.
// Pipeline stages: gain multiply, sign mix, min/max, shift, clamp,
// then four square-root stages of four result bits each.
// Throughput is one item per cycle; the pipeline stalls as a whole when
// the output is stalled and its last stage holds an item, so nothing is lost
// or repeated. Empty stages do not fill during a stall.
// Reset clears the configuration registers and valid bits; while active is 0 the speeds
// are zero.
module quadrotor_motor_mixer import qmix_pkg::*; #(
    parameter int unsigned MAX_SPEED = MaxSpeedDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_thrust,
    input  logic signed [31:0] i_roll_torque,
    input  logic signed [31:0] i_pitch_torque,
    input  logic signed [31:0] i_yaw_torque,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [SpdW-1:0]    o_rotor_one_speed,
    output logic [SpdW-1:0]    o_rotor_two_speed,
    output logic [SpdW-1:0]    o_rotor_three_speed,
    output logic [SpdW-1:0]    o_rotor_four_speed,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    localparam int Lat = 5 + SqrtStages;
    localparam logic signed [SumW-1:0] Limit = SumW'(MAX_SPEED * MAX_SPEED * 256);

    logic        r_active;
    logic [31:0] r_thrust_gain, r_rp_gain, r_yaw_gain;
    logic [Lat-1:0] r_vld;
    logic [Lat-1:0] r_act;
    logic        w_en;

    assign w_en    = !(r_vld[Lat-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_thrust_gain <= '0;
            r_rp_gain     <= '0;
            r_yaw_gain    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                t_reg_active:     r_active      <= i_cfg_data[0];
                t_reg_thrust:     r_thrust_gain <= i_cfg_data;
                t_reg_roll_pitch: r_rp_gain     <= i_cfg_data;
                t_reg_yaw:        r_yaw_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_act <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
            r_act <= {r_act[Lat-2:0], r_active};
        end
    end

    // stage 1: gain products
    logic signed [TermW-1:0] w_f, w_r, w_p, w_y;
    qmix_term u_f (.i_clk, .i_en(w_en), .i_demand(i_thrust),       .i_gain(r_thrust_gain),
                   .o_term(w_f));
    qmix_term u_r (.i_clk, .i_en(w_en), .i_demand(i_roll_torque),  .i_gain(r_rp_gain),
                   .o_term(w_r));
    qmix_term u_p (.i_clk, .i_en(w_en), .i_demand(i_pitch_torque), .i_gain(r_rp_gain),
                   .o_term(w_p));
    qmix_term u_y (.i_clk, .i_en(w_en), .i_demand(i_yaw_torque),   .i_gain(r_yaw_gain),
                   .o_term(w_y));

    // stage 2: sign mix
    logic signed [SumW-1:0] r_s [4];
    logic signed [SumW-1:0] ef, er, ep, ey;
    assign ef = SumW'(w_f);
    assign er = SumW'(w_r);
    assign ep = SumW'(w_p);
    assign ey = SumW'(w_y);

    // stage 3: min/max; stage 4: shift; stage 5: clamp
    logic signed [SumW-1:0] r_s3 [4];
    logic signed [SumW-1:0] r_lo, r_hi;
    logic signed [SumW-1:0] r_s4 [4];
    t_sq_set r_sq;
    logic signed [SumW-1:0] w_lo01, w_lo23, w_hi01, w_hi23, w_fix;

    assign w_lo01 = (r_s[0] < r_s[1]) ? r_s[0] : r_s[1];
    assign w_lo23 = (r_s[2] < r_s[3]) ? r_s[2] : r_s[3];
    assign w_hi01 = (r_s[0] > r_s[1]) ? r_s[0] : r_s[1];
    assign w_hi23 = (r_s[2] > r_s[3]) ? r_s[2] : r_s[3];
    assign w_fix  = (r_lo < 0) ? -r_lo : ((r_hi > Limit) ? Limit - r_hi : '0);

    function automatic logic [SqW-1:0] clamp(input logic signed [SumW-1:0] v);
        if (v < 0) return '0;
        if (v > Limit) return SqW'(Limit);
        return SqW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[0] <= ef - er - ep - ey;
            r_s[1] <= ef - er + ep + ey;
            r_s[2] <= ef + er + ep - ey;
            r_s[3] <= ef + er - ep + ey;
            r_s3   <= r_s;
            r_lo   <= (w_lo01 < w_lo23) ? w_lo01 : w_lo23;
            r_hi   <= (w_hi01 > w_hi23) ? w_hi01 : w_hi23;
            for (int k = 0; k < 4; k++) r_s4[k] <= r_s3[k] + w_fix;
            r_sq.v1 <= clamp(r_s4[0]);
            r_sq.v2 <= clamp(r_s4[1]);
            r_sq.v3 <= clamp(r_s4[2]);
            r_sq.v4 <= clamp(r_s4[3]);
        end
    end

    // stages 6..9: square roots
    logic [SpdW-1:0] w_q1, w_q2, w_q3, w_q4;
    qmix_sqrt u_q1 (.i_clk, .i_en(w_en), .i_value(r_sq.v1), .o_root(w_q1));
    qmix_sqrt u_q2 (.i_clk, .i_en(w_en), .i_value(r_sq.v2), .o_root(w_q2));
    qmix_sqrt u_q3 (.i_clk, .i_en(w_en), .i_value(r_sq.v3), .o_root(w_q3));
    qmix_sqrt u_q4 (.i_clk, .i_en(w_en), .i_value(r_sq.v4), .o_root(w_q4));

    assign o_rotor_one_speed   = r_act[Lat-1] ? w_q1 : '0;
    assign o_rotor_two_speed   = r_act[Lat-1] ? w_q2 : '0;
    assign o_rotor_three_speed = r_act[Lat-1] ? w_q3 : '0;
    assign o_rotor_four_speed  = r_act[Lat-1] ? w_q4 : '0;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rotor_one_speed))
        else $error("output changed under stall");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");
    a_speed_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rotor_one_speed <= SpdW'(MAX_SPEED * 16)
                 && o_rotor_four_speed <= SpdW'(MAX_SPEED * 16))
        else $error("speed above limit");
endmodule

@@ tb/sv/quadrotor_motor_mixer_tb.sv @@
`timescale 1ns / 1ps
module quadrotor_motor_mixer_tb;
    import qmix_pkg::*;

    localparam int unsigned SpeedMax = MaxSpeedDefault;
    localparam int unsigned LatencyCycles = 9;
    localparam int unsigned WatchdogLimit = 20000;
    localparam int unsigned RandomItems = 1600;

    typedef struct {
        logic signed [31:0] thrust;
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } demand_t;

    typedef struct {
        logic [SpdW-1:0] s1;
        logic [SpdW-1:0] s2;
        logic [SpdW-1:0] s3;
        logic [SpdW-1:0] s4;
    } speeds_t;

    typedef struct {
        demand_t d;
        bit      has_fixed;
        speeds_t fixed;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] thrust_in;
    logic signed [31:0] roll_in;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic               out_valid;
    logic               out_stall;
    logic [SpdW-1:0]    sp1;
    logic [SpdW-1:0]    sp2;
    logic [SpdW-1:0]    sp3;
    logic [SpdW-1:0]    sp4;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [31:0]        cfg_data;

    quadrotor_motor_mixer uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_thrust(thrust_in), .i_roll_torque(roll_in),
        .i_pitch_torque(pitch_in), .i_yaw_torque(yaw_in),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_rotor_one_speed(sp1), .o_rotor_two_speed(sp2),
        .o_rotor_three_speed(sp3), .o_rotor_four_speed(sp4),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    // mixer settings as the block should hold them
    bit          mix_active;
    logic [31:0] gain_thrust;
    logic [31:0] gain_rp;
    logic [31:0] gain_yaw;

    speeds_t     speeds_due[$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned items_seen;
    int unsigned idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          holdoff_req;
    bit          holdoff_busy;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint demand_term(logic signed [31:0] dmd, logic [31:0] g);
        longint prod;
        prod = longint'(dmd) * longint'({32'd0, g});
        return prod >>> 16;  // arithmetic shift floors toward minus infinity
    endfunction

    function automatic logic [SpdW-1:0] floor_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res[SpdW-1:0];
    endfunction

    function automatic speeds_t mix_rotors(demand_t d);
        longint lim;
        longint f;
        longint r;
        longint p;
        longint y;
        longint sq[4];
        longint lo;
        longint hi;
        longint shift;
        logic [SpdW-1:0] sp[4];
        speeds_t o;
        lim = longint'(SpeedMax) * longint'(SpeedMax) * 256;
        if (!mix_active) begin
            o = '{default: '0};
            return o;
        end
        f = demand_term(d.thrust, gain_thrust);
        r = demand_term(d.roll, gain_rp);
        p = demand_term(d.pitch, gain_rp);
        y = demand_term(d.yaw, gain_yaw);
        sq[0] = f - r - p - y;
        sq[1] = f - r + p + y;
        sq[2] = f + r + p - y;
        sq[3] = f + r - p + y;
        lo = sq[0];
        hi = sq[0];
        for (int k = 1; k < 4; k++) begin
            if (sq[k] < lo) lo = sq[k];
            if (sq[k] > hi) hi = sq[k];
        end
        shift = 0;
        if (lo < 0) shift = -lo;
        else if (hi > lim) shift = lim - hi;
        for (int k = 0; k < 4; k++) begin
            longint v;
            v = sq[k] + shift;
            if (v < 0) v = 0;
            else if (v > lim) v = lim;
            sp[k] = floor_sqrt(v);
        end
        o.s1 = sp[0];
        o.s2 = sp[1];
        o.s3 = sp[2];
        o.s4 = sp[3];
        return o;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 items_seen);
        mismatches++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            t_reg_active:     mix_active  = val[0];
            t_reg_thrust:     gain_thrust = val;
            t_reg_roll_pitch: gain_rp     = val;
            t_reg_yaw:        gain_yaw    = val;
            default: ;
        endcase
    endtask

    task automatic set_mixer(int unsigned act, logic [31:0] gt, logic [31:0] gr,
                             logic [31:0] gy);
        write_reg(t_reg_active, {31'd0, act[0]});
        write_reg(t_reg_thrust, gt);
        write_reg(t_reg_roll_pitch, gr);
        write_reg(t_reg_yaw, gy);
    endtask

    // one item on the input channel; the expectation is queued at acceptance.
    // valid stays up after acceptance so the next item can follow at once
    task automatic send_item(demand_t d, bit has_fixed, speeds_t fixed);
        speeds_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        thrust_in <= d.thrust;
        roll_in   <= d.roll;
        pitch_in  <= d.pitch;
        yaw_in    <= d.yaw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = mix_rotors(d);
        if (has_fixed && want != fixed)
            $display("note: table row %0d disagrees with the predictor", items_sent);
        speeds_due.push_back(has_fixed ? fixed : want);
        items_sent++;
    endtask

    task automatic drain;
        int unsigned w;
        @(negedge clk);
        in_valid <= 1'b0;
        w = 0;
        while (speeds_due.size() != 0) @(posedge clk);
        while (w < LatencyCycles + 4) begin
            @(posedge clk);
            w++;
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000 | $urandom_range(255);
            1: return 32'h7FFF_FF00 | $urandom_range(255);
            2: return $urandom_range(255);
            3: return -$urandom_range(1 << 20);
            default: return $urandom();
        endcase
    endfunction

    function automatic demand_t rand_demand();
        demand_t d;
        d.thrust = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(1 << 22);
        d.roll   = ($urandom_range(3) == 0) ? rand_word() : $signed($urandom_range(1 << 20)) - (1 << 19);
        d.pitch  = ($urandom_range(3) == 0) ? rand_word() : $signed($urandom_range(1 << 20)) - (1 << 19);
        d.yaw    = ($urandom_range(3) == 0) ? rand_word() : $signed($urandom_range(1 << 20)) - (1 << 19);
        return d;
    endfunction

    // output side
    always @(negedge clk) begin
        if (holdoff_busy) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        holdoff_busy = 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff_req) begin
                holdoff_busy = 1'b1;
                repeat (200) @(posedge clk);
                holdoff_busy = 1'b0;
                wait (!holdoff_req);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (speeds_due.size() == 0) begin
                $display("unexpected result %0d", items_seen);
                mismatches++;
            end else begin
                speeds_t want;
                want = speeds_due.pop_front();
                if (sp1 !== want.s1) report_mismatch("rotor one", sp1, want.s1);
                if (sp2 !== want.s2) report_mismatch("rotor two", sp2, want.s2);
                if (sp3 !== want.s3) report_mismatch("rotor three", sp3, want.s3);
                if (sp4 !== want.s4) report_mismatch("rotor four", sp4, want.s4);
            end
            items_seen++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress, %0d results pending", speeds_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t row(logic [31:0] t, logic [31:0] r, logic [31:0] p,
                                      logic [31:0] y, int fx, int unsigned s);
        stim_row_t x;
        x.d = '{t, r, p, y};
        x.has_fixed = (fx != 0);
        x.fixed = '{SpdW'(s), SpdW'(s), SpdW'(s), SpdW'(s)};
        return x;
    endfunction

    initial begin
        speeds_t none;
        none = '{default: '0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        thrust_in = '0;
        roll_in = '0;
        pitch_in = '0;
        yaw_in = '0;
        cfg_we = 1'b0;
        cfg_idx = t_reg_active;
        cfg_data = '0;
        mix_active = 1'b0;
        gain_thrust = '0;
        gain_rp = '0;
        gain_yaw = '0;
        items_sent = 0;
        holdoff_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset: inactive, all zero whatever the demands
        directed.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0));
        directed.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0));
        foreach (directed[i]) send_item(directed[i].d, directed[i].has_fixed, directed[i].fixed);
        drain();

        // active with zero gains: still all zero
        set_mixer(1, 0, 0, 0);
        directed = {};
        directed.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1, 0));
        foreach (directed[i]) send_item(directed[i].d, directed[i].has_fixed, directed[i].fixed);
        drain();

        // full gains: extremes saturate or shift
        set_mixer(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed = {};
        directed.push_back(row(32'h7FFF_FFFF, 0, 0, 0, 1, SpeedMax * 16));
        directed.push_back(row(32'h8000_0000, 0, 0, 0, 1, 0));
        directed.push_back(row(0, 0, 0, 0, 1, 0));
        directed.push_back(row(0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        directed.push_back(row(0, 0, 32'h8000_0000, 0, 0, 0));
        directed.push_back(row(0, 0, 0, 32'h7FFF_FFFF, 0, 0));
        directed.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        foreach (directed[i]) send_item(directed[i].d, directed[i].has_fixed, directed[i].fixed);
        drain();

        // realistic gains: shortfall, excess, wide spread, small values
        set_mixer(1, 32'd2560, 32'd9000, 32'd40000);
        directed = {};
        directed.push_back(row(32'h0004_0000, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800, 0, 0));
        directed.push_back(row(32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0));
        directed.push_back(row(32'h0100_0000, 32'h0000_0100, 0, 0, 0, 0));
        directed.push_back(row(32'h0000_0001, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0));
        directed.push_back(row(32'h0020_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0000, 0, 0));
        directed.push_back(row(32'hFFF0_0000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 0, 0));
        foreach (directed[i]) send_item(directed[i].d, directed[i].has_fixed, directed[i].fixed);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 34 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                case (blk)
                    0: set_mixer(1, $urandom_range(4096), $urandom_range(65536),
                                 $urandom_range(1 << 18));
                    1: set_mixer(1, $urandom(), $urandom(), $urandom());
                    2: set_mixer($urandom_range(1), $urandom_range(1 << 12),
                                 $urandom_range(1 << 16), $urandom_range(1 << 20));
                    default: set_mixer(1, 32'hFFFF_FFFF, $urandom_range(1), 32'hFFFF_FFFF);
                endcase
                if (phase == 2 && blk == 0) holdoff_req = 1'b1;
                for (int n = 0; n < RandomItems / 12; n++) begin
                    send_item(rand_demand(), 1'b0, none);
                    if (n == 40) holdoff_req = 1'b0;
                end
                drain();
            end
        end
        set_mixer(0, 0, 0, 0);

        $display("sent %0d items, checked %0d results over several gain settings,",
                 items_sent, items_seen);
        $display("with input and output stalls, a long output hold-off and inactive runs");
        if (mismatches == 0 && speeds_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ quadrotor_motor_mixer.f @@
rtl/core/qmix_pkg.sv
rtl/core/qmix_term.sv
rtl/core/qmix_sqrt.sv
rtl/core/quadrotor_motor_mixer.sv
tb/sv/quadrotor_motor_mixer_tb.sv
